>>> hw/rtl/mcra_pkg.sv
package mcra_pkg;

    localparam int CH_W   = 5;
    localparam int TGT_W  = 4;
    localparam int MASK_W = 1 << TGT_W;

    // configuration register indexes
    localparam logic CFG_RESERVE_LOW  = 1'b0;
    localparam logic CFG_RESERVE_HIGH = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        logic            was_remapped;
        logic            no_free;
    } t_result;

    typedef struct packed {
        logic             we;
        logic             clr;
        logic [TGT_W-1:0] idx;
        logic [TGT_W-1:0] target;
    } t_tbl_wr;

    typedef struct packed {
        logic             valid;
        logic [TGT_W-1:0] target;
    } t_tbl_rd;

endpackage

>>> hw/rtl/mcra_in_if.sv
interface mcra_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [mcra_pkg::CH_W-1:0] in_channel;

    modport source (output valid, output command, output in_channel, input ready);
    modport sink   (input valid, input command, input in_channel, output ready);
endinterface

>>> hw/rtl/mcra_out_if.sv
interface mcra_out_if;
    logic                      valid;
    logic                      ready;
    logic [mcra_pkg::CH_W-1:0] out_channel;
    logic                      was_remapped;
    logic                      no_free;

    modport source (output valid, output out_channel, output was_remapped, output no_free,
                    input ready);
    modport sink   (input valid, input out_channel, input was_remapped, input no_free,
                    output ready);
endinterface

>>> hw/rtl/midi_channel_remap_allocator.sv
// Channel  Dir  Handshake        Payload
// i_in     in   valid / ready    command, in_channel
// o_out    out  valid / ready    out_channel, was_remapped, no_free
// i_cfg    in   write enable     i_cfg_idx, i_cfg_data
//
// An in-range item makes one table pass that gathers the claimed targets and, when
// it needs a new target and its own entry holds none, a downward candidate walk
// over the same single table read port. An out-of-range item skips both.
// The result sits in an output register; a stalled output holds the next finished
// item in the sequencer until the register frees. Reset clears the table's valid bits.
module midi_channel_remap_allocator #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mcra_in_if.sink         i_in,
    mcra_out_if.source      o_out,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic            i_cfg_data
);
    localparam int IW = $clog2(NUM_CHANNELS);

    logic                    r_reserve_low;
    logic                    r_reserve_high;
    logic                    r_out_valid;
    mcra_pkg::t_result       r_out;

    logic                    slot_free;
    logic                    res_load;
    mcra_pkg::t_result       res;
    logic [IW-1:0]           rd_addr;
    mcra_pkg::t_tbl_rd       rd;
    mcra_pkg::t_tbl_wr       wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserve_low  <= 1'b1;
            r_reserve_high <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcra_pkg::CFG_RESERVE_LOW:  r_reserve_low  <= i_cfg_data;
                mcra_pkg::CFG_RESERVE_HIGH: r_reserve_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign slot_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    mcra_seq #(.NUM_CHANNELS(NUM_CHANNELS)) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_command      (i_in.command),
        .i_in_channel   (i_in.in_channel),
        .i_reserve_low  (r_reserve_low),
        .i_reserve_high (r_reserve_high),
        .i_slot_free    (slot_free),
        .o_res_load     (res_load),
        .o_res          (res),
        .o_rd_addr      (rd_addr),
        .i_rd           (rd),
        .o_wr           (wr)
    );

    mcra_table #(.NUM_CHANNELS(NUM_CHANNELS)) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_wr      (wr)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.out_channel  = r_out.out_channel;
    assign o_out.was_remapped = r_out.was_remapped;
    assign o_out.no_free      = r_out.no_free;

endmodule

>>> hw/rtl/mcra_table.sv
module mcra_table #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(NUM_CHANNELS)-1:0]   i_rd_addr,
    output mcra_pkg::t_tbl_rd                 o_rd,
    input  mcra_pkg::t_tbl_wr                 i_wr
);
    localparam int IW = $clog2(NUM_CHANNELS);

    logic [NUM_CHANNELS-1:0]           r_valid;
    logic [mcra_pkg::TGT_W-1:0]        r_target [NUM_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.idx[IW-1:0]] <= !i_wr.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_target[i_wr.idx[IW-1:0]] <= i_wr.clr ? '0 : i_wr.target;
        end
    end

    assign o_rd.valid  = r_valid[i_rd_addr];
    assign o_rd.target = r_target[i_rd_addr];

endmodule

>>> hw/rtl/mcra_seq.sv
module mcra_seq #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [mcra_pkg::CH_W-1:0]         i_in_channel,
    input  logic                              i_reserve_low,
    input  logic                              i_reserve_high,
    input  logic                              i_slot_free,
    output logic                              o_res_load,
    output mcra_pkg::t_result                 o_res,
    output logic [$clog2(NUM_CHANNELS)-1:0]   o_rd_addr,
    input  mcra_pkg::t_tbl_rd                 i_rd,
    output mcra_pkg::t_tbl_wr                 o_wr
);
    localparam int IW = $clog2(NUM_CHANNELS);
    localparam logic [IW-1:0] LAST = IW'(NUM_CHANNELS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic                            r_cmd;
    logic                            r_inr;
    logic [IW-1:0]                   r_idx;
    logic [IW-1:0]                   r_ptr;
    logic [IW-1:0]                   r_lo;
    logic [mcra_pkg::MASK_W-1:0]     r_tmask;
    logic                            r_cap_valid;
    logic [mcra_pkg::TGT_W-1:0]      r_cap_tgt;
    logic                            r_alloc;
    mcra_pkg::t_result               r_res;

    logic                            need;
    logic                            cand_free;
    logic [IW-1:0]                   hi;
    logic [IW-1:0]                   lo;
    logic                            in_range;

    assign in_range = (i_in_channel != '0) &&
                      (i_in_channel <= mcra_pkg::CH_W'(NUM_CHANNELS));
    assign need = (r_idx == '0 && i_reserve_low) ||
                  (r_idx == LAST && i_reserve_high) ||
                  r_cap_valid || r_tmask[mcra_pkg::TGT_W'(r_idx)];
    assign hi = LAST - IW'(i_reserve_high);
    assign lo = IW'(i_reserve_low);
    assign cand_free = !i_rd.valid && !r_tmask[mcra_pkg::TGT_W'(r_ptr)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd       <= i_command;
                        r_inr       <= in_range;
                        r_idx       <= IW'(i_in_channel - mcra_pkg::CH_W'(1));
                        r_ptr       <= '0;
                        r_tmask     <= '0;
                        r_cap_valid <= 1'b0;
                        r_alloc     <= 1'b0;
                        r_res       <= '{out_channel: i_in_channel, was_remapped: 1'b0,
                                         no_free: 1'b0};
                        r_state     <= in_range ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    // collect every claimed target and pick up our own entry
                    if (i_rd.valid) begin
                        r_tmask[i_rd.target] <= 1'b1;
                    end
                    if (r_ptr == r_idx) begin
                        r_cap_valid <= i_rd.valid;
                        r_cap_tgt   <= i_rd.target;
                    end
                    if (r_ptr == LAST) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_ptr <= hi;
                    r_lo  <= lo;
                    priority if (!need) begin
                        r_state <= S_DONE;
                    end else if (r_cap_valid) begin
                        r_res   <= '{out_channel: mcra_pkg::CH_W'(r_cap_tgt) +
                                                  mcra_pkg::CH_W'(1),
                                     was_remapped: 1'b1, no_free: 1'b0};
                        r_state <= S_DONE;
                    end else if (hi < lo) begin
                        r_res   <= '{out_channel: '0, was_remapped: 1'b0, no_free: 1'b1};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // walk candidates from the top down
                    priority if (cand_free) begin
                        r_alloc <= 1'b1;
                        r_res   <= '{out_channel: mcra_pkg::CH_W'(r_ptr) + mcra_pkg::CH_W'(1),
                                     was_remapped: 1'b1, no_free: 1'b0};
                        r_state <= S_DONE;
                    end else if (r_ptr == r_lo) begin
                        r_res   <= '{out_channel: '0, was_remapped: 1'b0, no_free: 1'b1};
                        r_state <= S_DONE;
                    end else begin
                        r_ptr <= r_ptr - 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_res_load = (r_state == S_DONE) && i_slot_free;
    assign o_res      = r_res;
    assign o_rd_addr  = r_ptr;

    always_comb begin
        o_wr.we     = o_res_load && r_inr && (r_cmd || r_alloc);
        o_wr.clr    = r_cmd;
        o_wr.idx    = mcra_pkg::TGT_W'(r_idx);
        o_wr.target = mcra_pkg::TGT_W'(r_ptr);
    end

endmodule

>>> hw/rtl/mcra_checker.sv
module mcra_checker #(
    parameter int NUM_CHANNELS = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [mcra_pkg::CH_W-1:0] i_out_channel,
    input logic                      i_was_remapped,
    input logic                      i_no_free
);

    // the block holds one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_channel))
        else $error("stalled result dropped or changed");

    a_no_free_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_no_free |-> i_out_channel == '0 && !i_was_remapped)
        else $error("no-free result carries a channel");

    a_remap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_was_remapped |->
            i_out_channel != '0 && i_out_channel <= mcra_pkg::CH_W'(NUM_CHANNELS))
        else $error("remapped channel out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind midi_channel_remap_allocator mcra_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_mcra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_channel  (o_out.out_channel),
    .i_was_remapped (o_out.was_remapped),
    .i_no_free      (o_out.no_free)
);

>>> verif/midi_channel_remap_allocator_test.sv
`timescale 1ns / 1ps

module midi_channel_remap_allocator_test;

    localparam int NCH        = 16;
    localparam int IDLE_PCT   = 19;
    localparam int SETTLE     = 40;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 300;
    localparam int PHASE_LEN  = 220;
    localparam int CYCLE_MAX  = 300000;

    typedef struct {
        bit                        release_cmd;
        logic [mcra_pkg::CH_W-1:0] channel;
    } t_note_evt;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_data;

    mcra_in_if  note_in ();
    mcra_out_if note_out ();

    midi_channel_remap_allocator #(
        .NUM_CHANNELS (NCH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (note_in),
        .o_out      (note_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the channel table and the reserve flags
    bit                         map_used [NCH];
    logic [mcra_pkg::TGT_W-1:0] map_to   [NCH];
    bit                         keep_low;
    bit                         keep_high;

    t_note_evt         pending_events[$];
    mcra_pkg::t_result expected_remaps[$];
    int        events_queued;
    int        events_taken;
    int        results_seen;
    int        fail_count;
    int        hold_left;
    int        cycle_count;
    bit        calm;

    function automatic bit is_claimed(int tgt, int skip);
        for (int k = 0; k < NCH; k++) begin
            if (k != skip && map_used[k] && int'(map_to[k]) == tgt) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic mcra_pkg::t_result remap_lookup(bit release_cmd,
                                                       logic [mcra_pkg::CH_W-1:0] ch);
        mcra_pkg::t_result r;
        int      slot;
        int      hi;
        int      lo;
        bit      need;
        r.out_channel  = ch;
        r.was_remapped = 1'b0;
        r.no_free      = 1'b0;
        if (ch >= 1 && ch <= NCH) begin
            slot = int'(ch) - 1;
            need = (slot == 0 && keep_low) || (slot == NCH - 1 && keep_high) ||
                   map_used[slot] || is_claimed(slot, slot);
            if (need) begin
                if (map_used[slot]) begin
                    r.out_channel  = mcra_pkg::CH_W'(map_to[slot]) + 1'b1;
                    r.was_remapped = 1'b1;
                end else begin
                    hi = NCH - 1 - int'(keep_high);
                    lo = int'(keep_low);
                    r.out_channel = '0;
                    r.no_free     = 1'b1;
                    // take the highest channel that is neither mapped nor claimed
                    for (int c = hi; c >= lo; c--) begin
                        if (!map_used[c] && !is_claimed(c, -1)) begin
                            map_used[slot] = 1'b1;
                            map_to[slot]   = mcra_pkg::TGT_W'(c);
                            r.out_channel  = mcra_pkg::CH_W'(c + 1);
                            r.was_remapped = 1'b1;
                            r.no_free      = 1'b0;
                            break;
                        end
                    end
                end
            end
            if (release_cmd) begin
                map_used[slot] = 1'b0;
                map_to[slot]   = '0;
            end
        end
        return r;
    endfunction

    task automatic push_event(bit release_cmd, int ch);
        t_note_evt e;
        e.release_cmd = release_cmd;
        e.channel     = mcra_pkg::CH_W'(ch);
        pending_events.push_back(e);
        events_queued++;
    endtask

    task automatic write_cfg(logic idx, bit val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == mcra_pkg::CFG_RESERVE_LOW) begin
            keep_low = val;
        end else begin
            keep_high = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (events_taken != events_queued || expected_remaps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_burst();
        int kind;
        int len;
        int ch;
        kind = $urandom_range(99);
        if (kind < 40) begin
            // descending chain: a lookup can land on the previous item's target
            ch  = ($urandom_range(1) == 0) ? 1 : NCH;
            len = $urandom_range(15, 3);
            if (ch == 1) begin
                push_event($urandom_range(9) == 0, 1);
                ch = NCH;
            end
            for (int i = 0; i < len && ch >= 1; i++) begin
                push_event($urandom_range(9) == 0, ch);
                ch--;
            end
        end else if (kind < 60) begin
            len = $urandom_range(8, 3);
            for (int i = 0; i < len; i++) begin
                push_event(1'b0, $urandom_range(NCH, 1));
            end
        end else if (kind < 80) begin
            len = $urandom_range(8, 2);
            for (int i = 0; i < len; i++) begin
                push_event(1'b1, $urandom_range(NCH, 1));
            end
        end else if (kind < 90) begin
            for (int i = 1; i <= NCH; i++) begin
                push_event(1'b1, i);
            end
        end else begin
            len = $urandom_range(6, 2);
            for (int i = 0; i < len; i++) begin
                push_event(1'($urandom_range(1)), $urandom_range(31));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_remaps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sender: advance to the next item once the current one is taken
    always @(posedge i_clk) begin
        t_note_evt e;
        if (!i_rst_n) begin
            note_in.valid <= 1'b0;
        end else begin
            if (note_in.valid && note_in.ready) begin
                expected_remaps.push_back(remap_lookup(note_in.command, note_in.in_channel));
                events_taken++;
            end
            if (!note_in.valid || note_in.ready) begin
                if (pending_events.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    e = pending_events.pop_front();
                    note_in.valid      <= 1'b1;
                    note_in.command    <= e.release_cmd;
                    note_in.in_channel <= e.channel;
                end else begin
                    note_in.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each item against the oldest prediction
    always @(posedge i_clk) begin
        mcra_pkg::t_result want;
        bit      start_hold;
        start_hold = 1'b0;
        if (!i_rst_n) begin
            note_out.ready <= 1'b0;
        end else begin
            if (note_out.valid && note_out.ready) begin
                results_seen++;
                start_hold = (results_seen == HOLD_AT);
                if (expected_remaps.size() == 0) begin
                    $display("%0t: unexpected result ch=%0d remap=%0b nofree=%0b", $time,
                             note_out.out_channel, note_out.was_remapped, note_out.no_free);
                    fail_count++;
                end else begin
                    want = expected_remaps.pop_front();
                    if (note_out.out_channel !== want.out_channel) begin
                        $display("%0t: out_channel expected %0d got %0d", $time,
                                 want.out_channel, note_out.out_channel);
                        fail_count++;
                    end
                    if (note_out.was_remapped !== want.was_remapped) begin
                        $display("%0t: was_remapped expected %0b got %0b", $time,
                                 want.was_remapped, note_out.was_remapped);
                        fail_count++;
                    end
                    if (note_out.no_free !== want.no_free) begin
                        $display("%0t: no_free expected %0b got %0b", $time,
                                 want.no_free, note_out.no_free);
                        fail_count++;
                    end
                end
            end
            // hold off for a long stretch once so the block backs up
            if (start_hold) begin
                hold_left      <= HOLD_LEN;
                note_out.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left      <= hold_left - 1;
                note_out.ready <= 1'b0;
            end else begin
                note_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        bit low_set [4];
        bit high_set [4];
        int start;
        low_set  = '{1'b0, 1'b1, 1'b0, 1'b1};
        high_set = '{1'b0, 1'b1, 1'b1, 1'b0};

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = mcra_pkg::CFG_RESERVE_LOW;
        i_cfg_data          = 1'b0;
        note_in.valid       = 1'b0;
        note_in.command     = 1'b0;
        note_in.in_channel  = '0;
        note_out.ready      = 1'b0;
        keep_low            = 1'b1;
        keep_high           = 1'b0;
        calm                = 1'b0;
        events_queued       = 0;
        events_taken        = 0;
        results_seen        = 0;
        fail_count          = 0;
        hold_left           = 0;
        cycle_count         = 0;
        for (int k = 0; k < NCH; k++) begin
            map_used[k] = 1'b0;
            map_to[k]   = '0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: out of range, pass-through, chain until no channel is free
        push_event(1'b0, 0);
        push_event(1'b0, 31);
        push_event(1'b1, 17);
        push_event(1'b0, 2);
        push_event(1'b1, 5);
        push_event(1'b0, 1);
        for (int ch = NCH; ch >= 2; ch--) begin
            push_event(1'b0, ch);
        end
        push_event(1'b0, 1);
        push_event(1'b1, 2);
        push_event(1'b1, NCH);
        push_event(1'b1, 1);
        // unmapped release that allocates and clears at once
        push_event(1'b1, 1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            write_cfg(mcra_pkg::CFG_RESERVE_LOW, low_set[p]);
            write_cfg(mcra_pkg::CFG_RESERVE_HIGH, high_set[p]);
            calm  = (p == 3);
            start = events_queued;
            while (events_queued - start < PHASE_LEN) begin
                add_burst();
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
